/* hdl/assert_macros.svh */
// Assertion macros used by the port-level checker of the cosine similarity engine.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while reset is released.
`define CSIM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion lbl failed");

// Next-cycle implication checked while reset is released.
`define CSIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion lbl failed");

// Implication checked at every edge, reset included.
`define CSIM_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion lbl failed");

`endif

/* hdl/csim_pkg.sv */
// Types and constants shared by the cosine similarity engine modules.
// No dependencies.
`default_nettype none

package csim_pkg;

    localparam int DOT_W  = 42;
    localparam int NORM_W = 41;
    localparam int SIM_W  = 16;
    localparam int Q_DEPTH = 2;
    localparam int Q_CNT_W = 2;

    localparam logic [DOT_W-1:0]  DOT_MAX  = {1'b0, {(DOT_W-1){1'b1}}};
    localparam logic [DOT_W-1:0]  DOT_MIN  = {1'b1, {(DOT_W-1){1'b0}}};
    localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       norm_a;
        logic [NORM_W-1:0]       norm_b;
    } sums_t;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] free;
    } q_status_t;

endpackage

`default_nettype wire

/* hdl/csim_front.sv */
// Front end: takes element pairs, forms products and keeps the saturating running sums.
// Depends on csim_pkg; pushes the finished sums of each vector into csim_queue.
`default_nettype none

module csim_front
    import csim_pkg::*;
#(
    parameter int ELEMENT_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [15:0]       elem_a,
    input  wire logic [15:0]       elem_b,
    input  wire logic              last_element,
    input  wire q_status_t         q_status,
    output logic                   push,
    output sums_t                  push_data
);

    localparam int PW  = 2 * ELEMENT_BITS;
    localparam int SW  = ((PW > DOT_W) ? PW : DOT_W) + 1;

    logic [ELEMENT_BITS-1:0] ea;
    logic [ELEMENT_BITS-1:0] eb;

    generate
        if (ELEMENT_BITS <= 16) begin : g_narrow
            assign ea = elem_a[ELEMENT_BITS-1:0];
            assign eb = elem_b[ELEMENT_BITS-1:0];
        end
        else begin : g_wide
            assign ea = {{(ELEMENT_BITS-16){1'b0}}, elem_a};
            assign eb = {{(ELEMENT_BITS-16){1'b0}}, elem_b};
        end
    endgenerate

    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic signed [PW-1:0] pab_reg;
    logic signed [PW-1:0] paa_reg;
    logic signed [PW-1:0] pbb_reg;

    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [NORM_W-1:0]       na_reg, na_next;
    logic [NORM_W-1:0]       nb_reg, nb_next;

    logic signed [SW-1:0] dot_sum;
    logic signed [SW-1:0] na_sum;
    logic signed [SW-1:0] nb_sum;
    logic signed [SW-1:0] dmax;
    logic signed [SW-1:0] dmin;
    logic signed [SW-1:0] nmax;
    logic                 accept;
    sums_t                sat;

    assign in_ready = q_status.free > Q_CNT_W'(s1_valid_reg && s1_last_reg);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept && last_element;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pab_reg <= $signed(ea) * $signed(eb);
            paa_reg <= $signed(ea) * $signed(ea);
            pbb_reg <= $signed(eb) * $signed(eb);
        end
    end

    always_comb
    begin
        dmax    = SW'($signed(DOT_MAX));
        dmin    = SW'($signed(DOT_MIN));
        nmax    = SW'($signed({1'b0, NORM_MAX}));
        dot_sum = SW'(dot_reg) + SW'(pab_reg);
        na_sum  = SW'($signed({1'b0, na_reg})) + SW'(paa_reg);
        nb_sum  = SW'($signed({1'b0, nb_reg})) + SW'(pbb_reg);

        if (dot_sum > dmax)
        begin
            sat.dot = DOT_MAX;
        end
        else if (dot_sum < dmin)
        begin
            sat.dot = DOT_MIN;
        end
        else
        begin
            sat.dot = dot_sum[DOT_W-1:0];
        end
        sat.norm_a = (na_sum > nmax) ? NORM_MAX : na_sum[NORM_W-1:0];
        sat.norm_b = (nb_sum > nmax) ? NORM_MAX : nb_sum[NORM_W-1:0];

        dot_next = dot_reg;
        na_next  = na_reg;
        nb_next  = nb_reg;
        if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                dot_next = '0;
                na_next  = '0;
                nb_next  = '0;
            end
            else
            begin
                dot_next = sat.dot;
                na_next  = sat.norm_a;
                nb_next  = sat.norm_b;
            end
        end
    end

    assign push      = s1_valid_reg && s1_last_reg;
    assign push_data = sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end
        else
        begin
            dot_reg <= dot_next;
            na_reg  <= na_next;
            nb_reg  <= nb_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/csim_queue.sv */
// Two-entry queue of finished vector sums between the front and back ends.
// Depends on csim_pkg.
`default_nettype none

module csim_queue
    import csim_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire sums_t push_data,
    input  wire logic  pop,
    output sums_t      head,
    output q_status_t  status
);

    sums_t              mem_reg [Q_DEPTH];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.empty = (cnt_reg == '0);
    assign status.free  = Q_CNT_W'(Q_DEPTH) - cnt_reg;

endmodule

`default_nettype wire

/* hdl/csim_back.sv */
// Back end: turns one vector's sums into a Q1.15 cosine with a serial multiplier and a
// bit-by-bit magnitude search, and holds the result in the output register. Uses csim_pkg.
`default_nettype none

module csim_back
    import csim_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sums_t     head,
    input  wire q_status_t q_status,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [SIM_W-1:0] similarity,
    output logic           zero_norm
);

    localparam int MW        = 128;
    localparam int MYW       = 42;
    localparam int DIG       = 8;
    localparam int MUL_STEPS = MYW / DIG + 1;
    localparam int MCW       = 3;
    localparam int MAGW      = 17;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SQ   = 5'b00100,
        S_CMP  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        K_P = 3'b001,
        K_D = 3'b010,
        K_L = 3'b100
    } kind_t;

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [MW-1:0]      mx_reg, mx_next;
    logic [MYW-1:0]     my_reg, my_next;
    logic [MW-1:0]      macc_reg, macc_next;
    logic [MCW-1:0]     mcnt_reg, mcnt_next;
    logic [MW-1:0]      p_reg, p_next;
    logic [MW-1:0]      rhs_reg, rhs_next;
    logic [DOT_W-1:0]   dmag_reg, dmag_next;
    logic               neg_reg, neg_next;
    logic               zn_reg, zn_next;
    logic [MAGW-1:0]    m_reg, m_next;
    logic [3:0]         bit_reg, bit_next;
    logic               ov_reg, ov_next;
    logic [SIM_W-1:0]   sim_reg, sim_next;
    logic               zo_reg, zo_next;

    logic [MAGW-1:0]    cand;
    logic [MAGW-1:0]    odd17;
    logic [15:0]        odd;
    logic [31:0]        sq;
    logic [MW-1:0]      mstep;
    logic [MAGW-1:0]    negm;

    always_comb
    begin
        cand  = m_reg | (MAGW'(1) << bit_reg);
        odd17 = (cand << 1) - MAGW'(1);
        odd   = odd17[15:0];
        sq    = 32'(odd) * 32'(odd);
        mstep = macc_reg + mx_reg * {{(MW-DIG){1'b0}}, my_reg[DIG-1:0]};
        negm  = MAGW'(0) - m_reg;

        state_next = state_reg;
        kind_next  = kind_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        macc_next  = macc_reg;
        mcnt_next  = mcnt_reg;
        p_next     = p_reg;
        rhs_next   = rhs_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        zn_next    = zn_reg;
        m_next     = m_reg;
        bit_next   = bit_reg;
        ov_next    = ov_reg;
        sim_next   = sim_reg;
        zo_next    = zo_reg;
        pop        = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop       = 1'b1;
                    neg_next  = head.dot[DOT_W-1];
                    dmag_next = head.dot[DOT_W-1] ? (DOT_W'(0) - head.dot) : head.dot;
                    m_next    = '0;
                    if (head.norm_a == '0 || head.norm_b == '0)
                    begin
                        zn_next    = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        zn_next    = 1'b0;
                        mx_next    = MW'(head.norm_a);
                        my_next    = MYW'(head.norm_b);
                        macc_next  = '0;
                        mcnt_next  = '0;
                        kind_next  = K_P;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                macc_next = mstep;
                mx_next   = mx_reg << DIG;
                my_next   = my_reg >> DIG;
                mcnt_next = mcnt_reg + MCW'(1);
                if (mcnt_reg == MCW'(MUL_STEPS - 1))
                begin
                    case (kind_reg)
                        K_P:
                        begin
                            p_next    = mstep;
                            mx_next   = MW'(dmag_reg);
                            my_next   = MYW'(dmag_reg);
                            macc_next = '0;
                            mcnt_next = '0;
                            kind_next = K_D;
                        end
                        K_D:
                        begin
                            rhs_next   = mstep << 32;
                            bit_next   = 4'd15;
                            state_next = S_SQ;
                        end
                        default:
                        begin
                            state_next = S_CMP;
                        end
                    endcase
                end
            end
            S_SQ:
            begin
                if (cand > MAGW'(32768))
                begin
                    if (bit_reg == 4'd0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        bit_next = bit_reg - 4'd1;
                    end
                end
                else
                begin
                    mx_next    = p_reg;
                    my_next    = MYW'(sq);
                    macc_next  = '0;
                    mcnt_next  = '0;
                    kind_next  = K_L;
                    state_next = S_MUL;
                end
            end
            S_CMP:
            begin
                if (macc_reg <= rhs_reg)
                begin
                    m_next = cand;
                end
                if (bit_reg == 4'd0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    bit_next   = bit_reg - 4'd1;
                    state_next = S_SQ;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    zo_next = zn_reg;
                    if (neg_reg)
                    begin
                        sim_next = negm[SIM_W-1:0];
                    end
                    else if (m_reg[15])
                    begin
                        sim_next = 16'h7FFF;
                    end
                    else
                    begin
                        sim_next = m_reg[SIM_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= K_P;
            mcnt_reg  <= '0;
            bit_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            mcnt_reg  <= mcnt_next;
            bit_reg   <= bit_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        macc_reg <= macc_next;
        p_reg    <= p_next;
        rhs_reg  <= rhs_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        zn_reg   <= zn_next;
        m_reg    <= m_next;
        sim_reg  <= sim_next;
        zo_reg   <= zo_next;
    end

    assign out_valid  = ov_reg;
    assign similarity = sim_reg;
    assign zero_norm  = zo_reg;

endmodule

`default_nettype wire

/* hdl/cosine_similarity_engine.sv */
// Top level of the cosine similarity engine: front end, sums queue and back end.
// Depends on csim_pkg, csim_front, csim_queue and csim_back.
//
// Element pairs are taken at one pair per clock cycle for as long as the sums queue has
// room; each pair marked last closes a vector and queues its sums. The back end then works
// through each vector's sums one at a time (a 41-bit by 41-bit product, a 42-bit square and
// up to sixteen trial products on a serial multiplier that takes eight bits of its operand
// per cycle), so a stream of short vectors is paced by the back end. Up to two finished
// vectors wait in the queue, and a computed result waits in the output register until it is
// taken.
`default_nettype none

module cosine_similarity_engine
    import csim_pkg::*;
#(
    parameter int ELEMENT_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [15:0]      elem_a,
    input  wire logic [15:0]      elem_b,
    input  wire logic             last_element,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [SIM_W-1:0]      similarity,
    output logic                  zero_norm
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    sums_t     push_data;
    sums_t     head;

    csim_front #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .elem_a       (elem_a),
        .elem_b       (elem_b),
        .last_element (last_element),
        .q_status     (q_status),
        .push         (push),
        .push_data    (push_data)
    );

    csim_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    csim_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .similarity (similarity),
        .zero_norm  (zero_norm)
    );

endmodule

`default_nettype wire

/* hdl/csim_checker.sv */
// Port-level checks for the cosine similarity engine, bound to the top level.
// Depends on assert_macros.svh and cosine_similarity_engine.
`default_nettype none
`include "assert_macros.svh"

module csim_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] similarity,
    input wire logic        zero_norm
);

    `CSIM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `CSIM_ASSERT_IMP(a_zero_forces_zero, clk, rst_n, out_valid && zero_norm, similarity == 16'h0000)
    `CSIM_ASSERT_ALWAYS(a_quiet_after_reset, clk, $past(!rst_n), !out_valid)

endmodule

bind cosine_similarity_engine csim_checker u_csim_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .similarity (similarity),
    .zero_norm  (zero_norm)
);

`default_nettype wire

/* sim/cosine_similarity_engine_test.sv */
// Self-checking testbench for cosine_similarity_engine: drives element pairs and checks
// each similarity beat against a built-in exact fixed-point predictor or typed table rows.
// Depends on csim_pkg and the engine RTL.
`default_nettype none

module cosine_similarity_engine_test;
    import csim_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SUM_HI = 64'sh1FFFFFFFFFF;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam int CYCLE_LIMIT = 800000;
    localparam int HOLD_START = 8000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [SIM_W-1:0] sim;
        logic             zn;
    } cos_result_t;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
        logic               typed;
        logic [SIM_W-1:0]   sim;
        logic               zn;
    } pair_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [15:0] elem_a;
    logic [15:0] elem_b;
    logic last_element;
    logic out_valid;
    logic out_ready;
    logic [SIM_W-1:0] similarity;
    logic zero_norm;

    longint dot_acc;
    longint norm_a_acc;
    longint norm_b_acc;
    cos_result_t pending_cos[$];
    int error_count;
    int cycle_count;
    bit stimulus_done;
    int burst_left;

    pair_row_t directed_pairs[] = '{
        '{16'sd0, 16'sd0, 1'b1, 1'b1, 16'd0, 1'b1},
        '{16'sd0, 16'sd5, 1'b1, 1'b1, 16'd0, 1'b1},
        '{-16'sd7, 16'sd0, 1'b1, 1'b1, 16'd0, 1'b1},
        '{16'sd32767, 16'sd32767, 1'b1, 1'b1, 16'd32767, 1'b0},
        '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, 16'd32767, 1'b0},
        '{-16'sd32768, 16'sd32767, 1'b1, 1'b1, 16'h8000, 1'b0},
        '{16'sd32767, -16'sd32768, 1'b1, 1'b1, 16'h8000, 1'b0},
        '{16'sd1, 16'sd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'sd0, 16'sd1, 1'b1, 1'b1, 16'd0, 1'b0},
        '{16'sd1, 16'sd1, 1'b1, 1'b1, 16'd32767, 1'b0},
        '{-16'sd1, 16'sd1, 1'b1, 1'b1, 16'h8000, 1'b0},
        '{16'sd3, 16'sd4, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'sd4, -16'sd3, 1'b1, 1'b0, 16'd0, 1'b0},
        '{16'sd100, 16'sd200, 1'b0, 1'b0, 16'd0, 1'b0},
        '{-16'sd300, 16'sd50, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'sd12345, -16'sd32768, 1'b1, 1'b0, 16'd0, 1'b0},
        '{16'sd0, 16'sd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{16'sd0, 16'sd0, 1'b1, 1'b1, 16'd0, 1'b1},
        '{16'h5555, 16'hAAAA, 1'b1, 1'b0, 16'd0, 1'b0},
        '{16'h7FFF, 16'h0001, 1'b1, 1'b0, 16'd0, 1'b0}
    };

    cosine_similarity_engine uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .elem_a(elem_a),
        .elem_b(elem_b),
        .last_element(last_element),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .similarity(similarity),
        .zero_norm(zero_norm)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint clamp_add(longint acc, longint p, longint lo, longint hi);
        longint s;
        s = acc + p;
        if (s > hi)
            return hi;
        if (s < lo)
            return lo;
        return s;
    endfunction

    function automatic bit accumulate_pair(input logic signed [15:0] a,
                                           input logic signed [15:0] b,
                                           input logic last,
                                           output cos_result_t res);
        longint sa;
        longint sb;
        longint unsigned mag;
        logic [127:0] prod;
        logic [127:0] bound;
        logic [127:0] trial;
        longint unsigned odd;
        int m;
        int cand;
        sa = a;
        sb = b;
        res = '0;
        dot_acc = clamp_add(dot_acc, sa * sb, SUM_LO, SUM_HI);
        norm_a_acc = clamp_add(norm_a_acc, sa * sa, 0, SUM_HI);
        norm_b_acc = clamp_add(norm_b_acc, sb * sb, 0, SUM_HI);
        if (!last)
            return 1'b0;
        if (norm_a_acc == 0 || norm_b_acc == 0)
        begin
            res.zn = 1'b1;
        end
        else
        begin
            mag = (dot_acc < 0) ? longint'(-dot_acc) : longint'(dot_acc);
            prod = 128'(norm_a_acc) * 128'(norm_b_acc);
            bound = (128'(mag) * 128'(mag)) << 32;
            m = 0;
            for (int bitpos = 15; bitpos >= 0; bitpos--)
            begin
                cand = m | (1 << bitpos);
                if (cand <= 32768)
                begin
                    odd = 2 * cand - 1;
                    trial = 128'(odd * odd) * prod;
                    if (trial <= bound)
                        m = cand;
                end
            end
            if (dot_acc >= 0)
                res.sim = (m > 32767) ? 16'd32767 : 16'(m);
            else
                res.sim = 16'(-m);
        end
        dot_acc = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
        return 1'b1;
    endfunction

    task automatic offer_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                              input logic last, input bit typed, input cos_result_t typed_res);
        cos_result_t res;
        bit emits;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        elem_a <= a;
        elem_b <= b;
        last_element <= last;
        do
            @(posedge clk);
        while (!in_ready);
        emits = accumulate_pair(a, b, last, res);
        if (emits)
        begin
            if (typed)
                res = typed_res;
            pending_cos = {pending_cos, res};
        end
    endtask

    function automatic logic signed [15:0] pick_elem();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sd0;
            3: return 16'($signed($urandom_range(0, 15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len);
        logic signed [15:0] a;
        logic signed [15:0] b;
        int shape;
        shape = $urandom_range(0, 5);
        for (int i = 0; i < len; i++)
        begin
            a = pick_elem();
            case (shape)
                0: b = a;
                1: b = -a;
                2: b = a + 16'($signed($urandom_range(0, 63)) - 32);
                3: b = 16'sd0;
                default: b = pick_elem();
            endcase
            offer_pair(a, b, i == len - 1, 1'b0, '0);
        end
    endtask

    initial
    begin
        int items;
        rst_n = 1'b0;
        in_valid = 1'b0;
        elem_a = '0;
        elem_b = '0;
        last_element = 1'b0;
        stimulus_done = 1'b0;
        error_count = 0;
        dot_acc = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
        burst_left = 50;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_pairs[i])
            offer_pair(directed_pairs[i].a, directed_pairs[i].b, directed_pairs[i].last,
                       directed_pairs[i].typed,
                       '{sim: directed_pairs[i].sim, zn: directed_pairs[i].zn});
        items = directed_pairs.size();
        while (items < 950)
        begin
            int len;
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(1, 8);
            send_vector(len);
            items += len;
        end
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin
        out_ready = 1'b0;
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        int mode;
        cycle_count <= cycle_count + 1;
        mode = (cycle_count / 500) % 4;
        if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_CYCLES)
            out_ready <= 1'b0;
        else if (mode == 0)
            out_ready <= 1'b1;
        else if (mode == 1)
            out_ready <= $urandom_range(0, 1);
        else if (mode == 2)
            out_ready <= ($urandom_range(0, 3) == 0);
        else
            out_ready <= ((cycle_count % 7) < 5);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cos.size() == 0)
            begin
                $error("similarity beat with nothing expected: %h", similarity);
                error_count++;
            end
            else
            begin
                cos_result_t want;
                want = pending_cos.pop_front();
                if (similarity !== want.sim)
                begin
                    $error("similarity: expected %h, got %h", want.sim, similarity);
                    error_count++;
                end
                if (zero_norm !== want.zn)
                begin
                    $error("zero_norm: expected %b, got %b", want.zn, zero_norm);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        while (pending_cos.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("cosine_similarity_engine_test: clean");
        else
            $display("cosine_similarity_engine_test: errors");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("cosine_similarity_engine_test: errors");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/csim_pkg.sv
hdl/csim_front.sv
hdl/csim_queue.sv
hdl/csim_back.sv
hdl/cosine_similarity_engine.sv
hdl/csim_checker.sv
sim/cosine_similarity_engine_test.sv
